### src/psum_pkg.sv
// ---------------------------------------------------------------------------
// psum_pkg: shared types and constants of the prefix sum tree engine
// Holds the index widths, the operation codes and the structs that pass
// between the sequencer, the tree store and the top level.
// ---------------------------------------------------------------------------
package psum_pkg;

    localparam int IDX_W       = 10;
    localparam int CNT_W       = IDX_W + 1;
    localparam int MAX_ENTRIES = 1 << IDX_W;
    localparam int DATA_W      = 64;
    localparam int FUNC_W      = 3;

    localparam logic [FUNC_W-1:0] FUNC_POINT_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREFIX    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANGE_SUM = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SELECT    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RANGE_ADD = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] amount;
        logic [DATA_W-1:0] target;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [CNT_W-1:0]  found;
        logic              status;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

### src/psum_alu.sv
// ---------------------------------------------------------------------------
// psum_alu: shared 64-bit add/subtract unit
// Adds or subtracts two signed words on a 65-bit path and reports whether
// the first operand is greater than the second when subtracting.
// ---------------------------------------------------------------------------
module psum_alu
    import psum_pkg::*;
(
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic              sub,
    output logic [DATA_W-1:0] sum,
    output logic              gt
);

    logic [DATA_W:0] a_ext;
    logic [DATA_W:0] b_ext;
    logic [DATA_W:0] sum_ext;

    always_comb begin
        a_ext   = {a[DATA_W-1], a};
        b_ext   = sub ? ~{b[DATA_W-1], b} : {b[DATA_W-1], b};
        sum_ext = a_ext + b_ext + {{DATA_W{1'b0}}, sub};
        sum     = sum_ext[DATA_W-1:0];
        gt      = !sum_ext[DATA_W] && (sum_ext != '0);
    end

endmodule

### src/psum_store.sv
// ---------------------------------------------------------------------------
// psum_store: tree node memory
// One write port and one registered read port over all tree nodes, with a
// clearing pass after reset that writes zero to every node in turn.
// ---------------------------------------------------------------------------
module psum_store
    import psum_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data,
    output logic              ready
);

    logic [DATA_W-1:0] mem [MAX_ENTRIES];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic [IDX_W-1:0]  clr_addr_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_W'(MAX_ENTRIES - 1)) begin
                clearing_next = 1'b0;
            end
        end
        wr_en   = clearing_reg ? 1'b1 : req.wr_en;
        wr_addr = clearing_reg ? clr_addr_reg : req.wr_addr;
        wr_data = clearing_reg ? '0 : req.wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

### src/psum_engine.sv
// ---------------------------------------------------------------------------
// psum_engine: tree walk sequencer
// Walks the update, query and descent paths of the binary indexed tree one
// node at a time, driving the node memory and the shared add/subtract unit.
// ---------------------------------------------------------------------------
module psum_engine
    import psum_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  cmd_t              cmd,
    input  logic [IDX_W-1:0]  m,
    input  logic              out_free,
    input  logic [DATA_W-1:0] rd_data,
    output logic              idle,
    output mem_req_t          mem_req,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EX   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [FUNC_W-1:0] func_reg,   func_next;
    logic [IDX_W-1:0]  lo_reg,     lo_next;
    logic [IDX_W-1:0]  hi_reg,     hi_next;
    logic [DATA_W-1:0] amt_reg,    amt_next;
    logic [DATA_W-1:0] k_reg,      k_next;
    logic [DATA_W-1:0] acc_reg,    acc_next;
    logic [CNT_W-1:0]  idx_reg,    idx_next;
    logic [IDX_W-1:0]  p_reg,      p_next;
    logic [IDX_W-1:0]  pos_reg,    pos_next;
    logic              phase_reg,  phase_next;
    logic              status_reg, status_next;

    logic              lo_ok;
    logic              hi_ok;
    logic              idx_valid;
    logic [CNT_W-1:0]  lowbit;
    logic [IDX_W-1:0]  q;
    logic              is_add;
    logic              is_pfx;
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic              alu_sub;
    logic [DATA_W-1:0] alu_sum;
    logic              alu_gt;

    psum_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .gt  (alu_gt)
    );

    always_comb begin
        lo_ok     = (cmd.lo != '0) && (cmd.lo <= m);
        hi_ok     = (cmd.hi != '0) && (cmd.hi <= m);
        idx_valid = (idx_reg != '0) && (idx_reg <= {1'b0, m});
        lowbit    = idx_reg & (~idx_reg + CNT_W'(1));
        q         = pos_reg + p_reg;
        is_add    = (func_reg == FUNC_POINT_ADD) || (func_reg == FUNC_RANGE_ADD);
        is_pfx    = (func_reg == FUNC_PREFIX) || (func_reg == FUNC_RANGE_SUM);
        alu_a     = is_add ? rd_data : (is_pfx ? acc_reg : k_reg);
        alu_b     = is_add ? amt_reg : rd_data;
        alu_sub   = (func_reg == FUNC_SELECT) ? 1'b1 : phase_reg;
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        amt_next    = amt_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        p_next      = p_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        mem_req     = '0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    func_next   = cmd.func;
                    lo_next     = cmd.lo;
                    hi_next     = cmd.hi;
                    amt_next    = cmd.amount;
                    k_next      = cmd.target;
                    acc_next    = '0;
                    phase_next  = 1'b0;
                    pos_next    = '0;
                    p_next      = IDX_W'(MAX_ENTRIES / 2);
                    idx_next    = {1'b0, cmd.lo};
                    status_next = 1'b0;
                    case (cmd.func)
                        FUNC_POINT_ADD: status_next = !lo_ok;
                        FUNC_PREFIX: begin
                            status_next = !hi_ok;
                            idx_next    = {1'b0, cmd.hi};
                        end
                        FUNC_RANGE_SUM: begin
                            status_next = !(lo_ok && hi_ok);
                            idx_next    = {1'b0, cmd.hi};
                        end
                        FUNC_SELECT:    status_next = 1'b0;
                        FUNC_RANGE_ADD: status_next = !(lo_ok && hi_ok);
                        default:        status_next = 1'b1;
                    endcase
                    state_next = status_next ? ST_DONE : ST_RD;
                end
            end
            ST_RD: begin
                if (is_add) begin
                    if (idx_valid) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg[IDX_W-1:0];
                        state_next      = ST_EX;
                    end else if ((func_reg == FUNC_RANGE_ADD) && !phase_reg) begin
                        phase_next = 1'b1;
                        idx_next   = {1'b0, hi_reg} + CNT_W'(1);
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (is_pfx) begin
                    if (idx_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg[IDX_W-1:0];
                        state_next      = ST_EX;
                    end else if ((func_reg == FUNC_RANGE_SUM) && !phase_reg) begin
                        phase_next = 1'b1;
                        idx_next   = {1'b0, lo_reg - 1'b1};
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    if (p_reg == '0) begin
                        state_next = ST_DONE;
                    end else if (q <= m) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = q;
                        state_next      = ST_EX;
                    end else begin
                        p_next = p_reg >> 1;
                    end
                end
            end
            ST_EX: begin
                state_next = ST_RD;
                if (is_add) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg[IDX_W-1:0];
                    mem_req.wr_data = alu_sum;
                    idx_next        = idx_reg + lowbit;
                end else if (is_pfx) begin
                    acc_next = alu_sum;
                    idx_next = idx_reg & (idx_reg - CNT_W'(1));
                end else begin
                    if (alu_gt) begin
                        k_next   = alu_sum;
                        pos_next = q;
                    end
                    p_next = p_reg >> 1;
                end
            end
            ST_DONE: begin
                res_valid = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res.sum    = acc_reg;
        res.found  = ((func_reg == FUNC_SELECT) && !status_reg) ?
                     ({1'b0, pos_reg} + CNT_W'(1)) : '0;
        res.status = status_reg;
    end

    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        amt_reg    <= amt_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        p_reg      <= p_next;
        pos_reg    <= pos_next;
        phase_reg  <= phase_next;
        status_reg <= status_next;
    end

    // Node zero is never touched by any tree walk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.rd_en |-> mem_req.rd_addr != '0)
        else $error("read of tree node zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == ST_EX) && is_add && idx_valid)
        else $error("tree write outside an update step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status) |-> (res.sum == '0) && (res.found == '0))
        else $error("ignored word carries a nonzero result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EX) |-> $past(mem_req.rd_en))
        else $error("execute step without a preceding read");

endmodule

### src/prefix_sum_tree_engine_unit.sv
// Each word holds the engine while it visits each tree node on its walk, skips select
// levels above m and steps between the two walks of a range operation; the result word becomes
// valid in the same cycle that s_tready returns. One word is in work at a time.
// After reset a clearing pass zeroes the 1024 tree nodes with s_tready low.
// Reset is synchronous and active low; entries_in_use resets to 1023.
// ---------------------------------------------------------------------------
// prefix_sum_tree_engine_unit: binary indexed tree engine
// Stream-in operations on a binary indexed tree of 64-bit sums with an APB
// register for the number of entries in use and a registered result stream.
// ---------------------------------------------------------------------------
module prefix_sum_tree_engine_unit
    import psum_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_index[9:0], second_index[19:10], amount[83:20], rank_target[147:84]
    input  logic [151:0] s_tdata,
    // func[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sum_value[63:0], found_index[74:64]
    output logic [79:0]  m_tdata,
    // status[0]
    output logic [0:0]   m_tuser
);

    localparam logic [2:0] ADDR_ENTRIES = 3'd0;

    logic [IDX_W-1:0]  entries_reg, entries_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [79:0]       m_tdata_reg,  m_tdata_next;
    logic [0:0]        m_tuser_reg,  m_tuser_next;

    cmd_t              cmd;
    mem_req_t          mem_req;
    result_t           res;
    logic [DATA_W-1:0] rd_data;
    logic              store_ready;
    logic              eng_idle;
    logic              res_valid;
    logic              out_free;
    logic              start;
    logic              cfg_write;

    always_comb begin
        cmd.func   = s_tuser;
        cmd.lo     = s_tdata[9:0];
        cmd.hi     = s_tdata[19:10];
        cmd.amount = s_tdata[83:20];
        cmd.target = s_tdata[147:84];
    end

    assign s_tready = eng_idle && store_ready;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    psum_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_data),
        .ready   (store_ready)
    );

    psum_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd       (cmd),
        .m         (entries_reg),
        .out_free  (out_free),
        .rd_data   (rd_data),
        .idle      (eng_idle),
        .mem_req   (mem_req),
        .res_valid (res_valid),
        .res       (res)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        entries_next = entries_reg;
        if (cfg_write && (paddr == ADDR_ENTRIES)) begin
            entries_next = pwdata[IDX_W-1:0];
        end
        prdata = (paddr == ADDR_ENTRIES) ? {{(32 - IDX_W){1'b0}}, entries_reg} : '0;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0, res.found, res.sum};
            m_tuser_next  = res.status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg  <= IDX_W'(MAX_ENTRIES - 1);
            m_tvalid_reg <= 1'b0;
        end else begin
            entries_reg  <= entries_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
